[src/scc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and codes for the satisfied-clause counter.
// No dependencies; imported by the counter and its testbench.
package scc_pkg;

	localparam int NUM_CLAUSES = 32;
	localparam int NUM_VARS    = 64;

	localparam int VAR_W    = 6;
	localparam int CLAUSE_W = 5;
	localparam int CODE_W   = 2;
	localparam int COUNT_W  = 6;

	localparam int VAR_AW  = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
	localparam int ENTRY_W = 2 * NUM_CLAUSES;
	localparam int SUM_W   = $clog2(NUM_CLAUSES + 1);

	typedef enum logic {
		MODE_LOAD   = 1'b0,
		MODE_ASSIGN = 1'b1
	} mode_t;

	typedef enum logic [CODE_W-1:0] {
		LIT_ABSENT = 2'd0,
		LIT_POS    = 2'd1,
		LIT_NEG    = 2'd2,
		LIT_UNUSED = 2'd3
	} lit_code_t;

endpackage

[src/sat_clause_satisfaction_counter.sv]
`timescale 1ns / 1ps
// Top level of the satisfied-clause counter.
// Depends on scc_pkg and on scc_ram for the literal store.

// Satisfied-clause counter. Raise start with mode = load to place one literal
// (positive, negative or absent) of clause clause_index in variable var_index;
// raise start with mode = assign to present one variable's truth value. Busy
// never rises, so a beat may be offered in every cycle. The rate is set by the
// literal store, a RAM read issued at the beat and consumed in the next cycle;
// a store hit on the entry written by the previous beat is forwarded. The assign
// beat flagged last_var raises done for exactly one cycle, done being registered
// from stage 1, with satisfied_count holding the number of clauses satisfied;
// the receiver must take it then. The satisfied marks clear for the next
// assignment. After reset the store reads as empty at once (per-entry valid
// flags), with no clearing pass.
module sat_clause_satisfaction_counter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          mode,
	input  logic [scc_pkg::VAR_W-1:0]     var_index,
	input  logic [scc_pkg::CLAUSE_W-1:0]  clause_index,
	input  logic [scc_pkg::CODE_W-1:0]    literal_code,
	input  logic                          var_value,
	input  logic                          last_var,
	output logic                          done,
	output logic [scc_pkg::COUNT_W-1:0]   satisfied_count
);

	import scc_pkg::*;

	// Stage 1: the beat whose store entry returns this cycle
	logic                s1_valid_q;
	mode_t               mode_s1;
	logic [VAR_W-1:0]    var_s1;
	logic [CLAUSE_W-1:0] clause_s1;
	lit_code_t           code_s1;
	logic                value_s1;
	logic                last_s1;

	logic [NUM_VARS-1:0]    entry_valid_q;
	logic [NUM_CLAUSES-1:0] marks_q;

	// Forward path for a write landing at the same edge as the next read
	logic               fwd_valid_q;
	logic [VAR_AW-1:0]  fwd_addr_q;
	logic [ENTRY_W-1:0] fwd_data_q;

	logic                   accept;
	logic [VAR_AW-1:0]      rd_addr;
	logic [VAR_AW-1:0]      addr_s1;
	logic [ENTRY_W-1:0]     ram_rdata;
	logic [ENTRY_W-1:0]     entry;
	logic [NUM_CLAUSES-1:0] pos_mask;
	logic [NUM_CLAUSES-1:0] neg_mask;
	logic [NUM_CLAUSES-1:0] clause_bit;
	logic [NUM_CLAUSES-1:0] pos_new;
	logic [NUM_CLAUSES-1:0] neg_new;
	logic [ENTRY_W-1:0]     wr_data;
	logic                   wr_en;
	logic                   var_ok;
	logic                   clause_ok;
	logic                   is_assign;
	logic [NUM_CLAUSES-1:0] marks_next;
	logic [SUM_W-1:0]       ones;
	logic [COUNT_W-1:0]     count_sat;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign rd_addr = var_index[VAR_AW-1:0];
	assign addr_s1 = var_s1[VAR_AW-1:0];

	scc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_VARS)
	) u_lit_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// Hold the beat in stage 1 while its store entry is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1   <= mode_t'(mode);
			var_s1    <= var_index;
			clause_s1 <= clause_index;
			code_s1   <= lit_code_t'(literal_code);
			value_s1  <= var_value;
			last_s1   <= last_var;
		end
	end

	// Entry as of now: forwarded write, else stored data, else empty
	always_comb begin
		priority if (fwd_valid_q && fwd_addr_q == addr_s1) begin
			entry = fwd_data_q;
		end else if (entry_valid_q[addr_s1]) begin
			entry = ram_rdata;
		end else begin
			entry = '0;
		end
	end

	assign pos_mask = entry[NUM_CLAUSES-1:0];
	assign neg_mask = entry[ENTRY_W-1:NUM_CLAUSES];

	assign var_ok     = {1'b0, var_s1} < (VAR_W+1)'(NUM_VARS);
	assign clause_ok  = {1'b0, clause_s1} < (CLAUSE_W+1)'(NUM_CLAUSES);
	assign clause_bit = NUM_CLAUSES'(1) << clause_s1;
	assign is_assign  = s1_valid_q && mode_s1 == MODE_ASSIGN;

	// Literal load: clear both bits of the clause, then set the coded one
	always_comb begin
		pos_new = pos_mask & ~clause_bit;
		neg_new = neg_mask & ~clause_bit;
		unique case (code_s1)
			LIT_POS:    pos_new = pos_new | clause_bit;
			LIT_NEG:    neg_new = neg_new | clause_bit;
			LIT_ABSENT: ;
			default:    ;
		endcase
	end

	assign wr_data = {neg_new, pos_new};
	assign wr_en   = s1_valid_q && mode_s1 == MODE_LOAD && var_ok && clause_ok;

	// Assignment: fold in the mask that the value selects
	always_comb begin
		marks_next = marks_q;
		if (var_ok) begin
			marks_next = marks_q | (value_s1 ? pos_mask : neg_mask);
		end
	end

	assign ones = SUM_W'($countones(marks_next));

	// Saturate the count to the result width
	always_comb begin
		if (SUM_W > COUNT_W && ones > SUM_W'({COUNT_W{1'b1}})) begin
			count_sat = '1;
		end else begin
			count_sat = COUNT_W'(ones);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			marks_q       <= '0;
			fwd_valid_q   <= 1'b0;
			done          <= 1'b0;
		end else begin
			fwd_valid_q <= wr_en;
			done        <= is_assign && last_s1;
			if (wr_en) begin
				entry_valid_q[addr_s1] <= 1'b1;
			end
			if (is_assign) begin
				// Drop the marks once the count is taken
				marks_q <= last_s1 ? '0 : marks_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= wr_data;
		end
		if (is_assign && last_s1) begin
			satisfied_count <= count_sat;
		end
	end

endmodule

[src/scc_ram.sv]
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module scc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the satisfied-clause counter: directed and random beats
// checked against a predictor of the literal store. Depends on scc_pkg and the counter RTL.
module tb_top;
	import scc_pkg::*;

	// Watchdog limit on cycles with neither a beat nor a result. The slowest correct
	// run idles only for short sender gaps (geometric, at most 77 % per cycle) and for
	// the result latency, so this limit is many times over what is needed.
	localparam int IDLE_LIMIT  = 1000;
	// Cycles let pass after the last result; ample for the result latency.
	localparam int TAIL_CYCLES = 6;
	localparam int MAX_REPORTS = 10;
	localparam int COUNT_MAX   = (1 << COUNT_W) - 1;

	// One input beat, field for field as on the ports.
	typedef struct {
		mode_t               md;
		logic [VAR_W-1:0]    var_i;
		logic [CLAUSE_W-1:0] cls;
		lit_code_t           code;
		logic                val;
		logic                last;
	} beat_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	mode_t               mode;
	logic [VAR_W-1:0]    var_index;
	logic [CLAUSE_W-1:0] clause_index;
	lit_code_t           literal_code;
	logic                var_value;
	logic                last_var;
	logic                done;
	logic [COUNT_W-1:0]  satisfied_count;

	// Predicted state: per-variable clause masks and the running satisfied marks.
	logic [NUM_CLAUSES-1:0] pos_clauses [NUM_VARS];
	logic [NUM_CLAUSES-1:0] neg_clauses [NUM_VARS];
	logic [NUM_CLAUSES-1:0] sat_marks;

	// Counts still owed by the block, oldest first.
	logic [COUNT_W-1:0] expected_counts [$];

	int send_idle_pct;
	int err_count;
	int n_beats;
	int n_loads;
	int n_counts;
	int stall_cycles;

	sat_clause_satisfaction_counter uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.mode            (mode),
		.var_index       (var_index),
		.clause_index    (clause_index),
		.literal_code    (literal_code),
		.var_value       (var_value),
		.last_var        (last_var),
		.done            (done),
		.satisfied_count (satisfied_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic beat_t mk_beat(mode_t md, int v, int c, lit_code_t code, bit val,
			bit last);
		beat_t b;
		b.md    = md;
		b.var_i = v[VAR_W-1:0];
		b.cls   = c[CLAUSE_W-1:0];
		b.code  = code;
		b.val   = val;
		b.last  = last;
		return b;
	endfunction

	// Advance the predicted state by one beat. Returns 1 when the beat emits a count.
	function automatic bit count_satisfied(input beat_t b, output logic [COUNT_W-1:0] count);
		logic [NUM_CLAUSES-1:0] sel;
		int n;
		count = '0;
		if (b.md == MODE_LOAD) begin
			// A load replaces the entry: drop both polarities, then set the coded one.
			// The unused code and absent both leave the entry empty; last_var is ignored.
			if (b.var_i < NUM_VARS && b.cls < NUM_CLAUSES) begin
				sel = '0;
				sel[b.cls] = 1'b1;
				pos_clauses[b.var_i] &= ~sel;
				neg_clauses[b.var_i] &= ~sel;
				if (b.code == LIT_POS)
					pos_clauses[b.var_i] |= sel;
				else if (b.code == LIT_NEG)
					neg_clauses[b.var_i] |= sel;
			end
			return 1'b0;
		end
		// A variable out of range adds nothing but still lets last_var emit.
		if (b.var_i < NUM_VARS)
			sat_marks |= b.val ? pos_clauses[b.var_i] : neg_clauses[b.var_i];
		if (!b.last)
			return 1'b0;
		n = $countones(sat_marks);
		if (n > COUNT_MAX)
			n = COUNT_MAX;
		count = n[COUNT_W-1:0];
		sat_marks = '0;
		return 1'b1;
	endfunction

	task automatic report_error(input string what, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("mismatch at %0t: %s, expected %0d, got %0d", $time, what, exp_v, got_v);
	endtask

	// Offer one beat, idling first at the sender's rate, and hold it until accepted.
	// Called at a rising edge; returns at the edge that accepted the beat, with start
	// still high so a following beat may go straight out.
	task automatic send_beat(input beat_t b);
		logic [COUNT_W-1:0] cnt;
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start        <= 1'b1;
		mode         <= b.md;
		var_index    <= b.var_i;
		clause_index <= b.cls;
		literal_code <= b.code;
		var_value    <= b.val;
		last_var     <= b.last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		n_beats++;
		if (b.md == MODE_LOAD)
			n_loads++;
		if (count_satisfied(b, cnt))
			expected_counts.push_back(cnt);
	endtask

	// Hold the sender off until every owed count has come, then let the pipe empty.
	task automatic wait_for_counts();
		start <= 1'b0;
		while (expected_counts.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Extremes of the fields and the special cases of the literal store.
	task automatic test_directed();
		send_idle_pct = 0;
		// Empty table: any assignment satisfies nothing.
		send_beat(mk_beat(MODE_ASSIGN, 0, 0, LIT_ABSENT, 1, 1));
		// last_var on a load must not emit.
		send_beat(mk_beat(MODE_LOAD, 63, 31, LIT_POS, 0, 1));
		send_beat(mk_beat(MODE_ASSIGN, 63, 0, LIT_ABSENT, 1, 1));
		// Replace the positive literal by a negative one in the same slot.
		send_beat(mk_beat(MODE_LOAD, 63, 31, LIT_NEG, 1, 0));
		send_beat(mk_beat(MODE_ASSIGN, 63, 31, LIT_ABSENT, 1, 1));
		send_beat(mk_beat(MODE_ASSIGN, 63, 31, LIT_UNUSED, 0, 1));
		// Unused code stores as absent and never satisfies.
		send_beat(mk_beat(MODE_LOAD, 0, 0, LIT_UNUSED, 1, 0));
		send_beat(mk_beat(MODE_ASSIGN, 0, 0, LIT_ABSENT, 0, 0));
		send_beat(mk_beat(MODE_ASSIGN, 0, 0, LIT_ABSENT, 1, 1));
		// Absent code clears an earlier positive literal.
		send_beat(mk_beat(MODE_LOAD, 5, 7, LIT_POS, 0, 0));
		send_beat(mk_beat(MODE_ASSIGN, 5, 7, LIT_ABSENT, 1, 1));
		send_beat(mk_beat(MODE_LOAD, 5, 7, LIT_ABSENT, 0, 0));
		send_beat(mk_beat(MODE_ASSIGN, 5, 7, LIT_ABSENT, 1, 1));
		// Two clauses in one variable, both polarities; marks accumulate then clear.
		send_beat(mk_beat(MODE_LOAD, 9, 0, LIT_POS, 0, 0));
		send_beat(mk_beat(MODE_LOAD, 9, 31, LIT_NEG, 0, 0));
		send_beat(mk_beat(MODE_LOAD, 10, 0, LIT_NEG, 0, 0));
		send_beat(mk_beat(MODE_ASSIGN, 9, 0, LIT_ABSENT, 1, 0));
		send_beat(mk_beat(MODE_ASSIGN, 9, 0, LIT_ABSENT, 0, 0));
		send_beat(mk_beat(MODE_ASSIGN, 10, 0, LIT_ABSENT, 0, 1));
		send_beat(mk_beat(MODE_ASSIGN, 10, 0, LIT_ABSENT, 1, 1));
		// Load straight after an assign to the same variable, then read it back.
		send_beat(mk_beat(MODE_LOAD, 10, 3, LIT_POS, 0, 0));
		send_beat(mk_beat(MODE_ASSIGN, 10, 0, LIT_ABSENT, 1, 1));
	endtask

	// Every clause satisfied: even clauses positive in one variable, odd negative in
	// another, then both variables set the satisfying way for the widest count.
	task automatic test_all_clauses();
		for (int c = 0; c < NUM_CLAUSES; c++) begin
			if (c % 2 == 0)
				send_beat(mk_beat(MODE_LOAD, 20, c, LIT_POS, 0, 0));
			else
				send_beat(mk_beat(MODE_LOAD, 21, c, LIT_NEG, 0, 0));
		end
		send_beat(mk_beat(MODE_ASSIGN, 20, 0, LIT_ABSENT, 1, 0));
		send_beat(mk_beat(MODE_ASSIGN, 21, 0, LIT_ABSENT, 0, 1));
		// Marks must have cleared: the opposite assignment satisfies none.
		send_beat(mk_beat(MODE_ASSIGN, 20, 0, LIT_ABSENT, 0, 0));
		send_beat(mk_beat(MODE_ASSIGN, 21, 0, LIT_ABSENT, 1, 1));
	endtask

	// Mostly well-formed traffic: batches of loads and complete assignments over a
	// small set of variables so that they hit loaded literals, with some noise beats.
	task automatic test_random(input int n_items, input int idle_pct);
		int sent;
		int len;
		int v;
		beat_t b;
		send_idle_pct = idle_pct;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(19))
				0, 1, 2: begin
					// Noise: anything the fields allow.
					b = mk_beat(mode_t'($urandom_range(1)), $urandom_range(63),
						$urandom_range(31), lit_code_t'($urandom_range(3)),
						1'($urandom_range(1)), 1'($urandom_range(1)));
					send_beat(b);
					sent++;
				end
				3, 4, 5, 6, 7, 8, 9: begin
					len = $urandom_range(1, 10);
					for (int i = 0; i < len; i++) begin
						v = ($urandom_range(9) < 7) ? $urandom_range(15) : $urandom_range(63);
						b = mk_beat(MODE_LOAD, v, $urandom_range(31),
							($urandom_range(9) < 8) ? lit_code_t'($urandom_range(1, 2))
								: lit_code_t'($urandom_range(3)),
							1'($urandom_range(1)), 1'($urandom_range(1)));
						send_beat(b);
						sent++;
					end
				end
				default: begin
					len = $urandom_range(1, 8);
					for (int i = 0; i < len; i++) begin
						v = ($urandom_range(9) < 7) ? $urandom_range(15) : $urandom_range(63);
						b = mk_beat(MODE_ASSIGN, v, $urandom_range(31),
							lit_code_t'($urandom_range(3)), 1'($urandom_range(1)),
							i == len - 1);
						send_beat(b);
						sent++;
					end
				end
			endcase
		end
	endtask

	// Each done cycle carries one count, taken at the edge that ends it.
	always @(posedge clk) begin
		logic [COUNT_W-1:0] want;
		if (arst_n && done) begin
			if (expected_counts.size() == 0) begin
				report_error("count with none owed", 'x, satisfied_count);
			end else begin
				want = expected_counts.pop_front();
				n_counts++;
				if (satisfied_count !== want)
					report_error("satisfied_count", want, satisfied_count);
			end
		end
	end

	// Drop the run if the block stops taking beats or producing counts.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no activity for %0d cycles", stall_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		start         = 1'b0;
		mode          = MODE_LOAD;
		var_index     = '0;
		clause_index  = '0;
		literal_code  = LIT_ABSENT;
		var_value     = 1'b0;
		last_var      = 1'b0;
		send_idle_pct = 0;
		err_count     = 0;
		n_beats       = 0;
		n_loads       = 0;
		n_counts      = 0;
		stall_cycles  = 0;
		sat_marks     = '0;
		for (int i = 0; i < NUM_VARS; i++) begin
			pos_clauses[i] = '0;
			neg_clauses[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_all_clauses();
		wait_for_counts();
		test_random(165, 11);
		wait_for_counts();
		test_random(165, 77);
		wait_for_counts();
		test_random(165, 0);
		wait_for_counts();

		while (expected_counts.size() != 0)
			report_error("count never came", expected_counts.pop_front(), 'x);
		$display("covered %0d beats (%0d literal loads), %0d counts checked, %0d errors",
			n_beats, n_loads, n_counts, err_count);
		$display("sender gaps at 0, 11 and 77 percent, with full drains between phases");
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
